@@ sv/integer_to_ascii_formatter_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2AF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2AF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/i2af_pkg.sv @@
package i2af_pkg;

    localparam logic [1:0] CMD_SDEC  = 2'd0;
    localparam logic [1:0] CMD_UDEC  = 2'd1;
    localparam logic [1:0] CMD_HEX32 = 2'd2;
    localparam logic [1:0] CMD_HEX64 = 2'd3;

    localparam int WORD_W     = 32;
    localparam int VALUE_W    = 64;
    localparam int NIB_W      = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * NIB_W;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 5;
    localparam int BIT_CNT_W  = $clog2(WORD_W);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    // letter base minus ten, so that base + nibble gives the letter
    localparam logic [CHAR_W-1:0] HEX_UPPER_BASE = 8'h37;
    localparam logic [CHAR_W-1:0] HEX_LOWER_BASE = 8'h57;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [VALUE_W-1:0] value;
        logic               upper_case;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_out;
        logic               last;
        logic [COUNT_W-1:0] char_count;
    } out_item_t;

    function automatic logic [NIB_W-1:0] bcd_adjust(input logic [NIB_W-1:0] d);
        return (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] n,
                                                      input logic upper);
        logic [CHAR_W-1:0] base;
        if (n < 4'd10)
            base = CHAR_ZERO;
        else
            base = upper ? HEX_UPPER_BASE : HEX_LOWER_BASE;
        return base + {{(CHAR_W-NIB_W){1'b0}}, n};
    endfunction

endpackage

@@ sv/integer_to_ascii_formatter_unit.sv @@
// Integer to ASCII formatter.
// Input channel num_valid/num_ready/num_item takes one number with a format
// command (signed or unsigned 32-bit decimal, 32-bit or 64-bit hex) and a
// hex letter case flag. Output channel chr_valid/chr_ready/chr_item gives
// its characters, most significant first, no leading zeros, each with a
// last marker and the running count.
// Decimal numbers go through a bit-serial binary to BCD converter, one bit
// per cycle. Leading zero digits are then dropped one per cycle, after which
// one character leaves per cycle while the receiver does not stall.
// One number is worked on at a time; num_ready is high only when idle.
// The output register holds a character while chr_ready is low; the block
// waits without losing or repeating anything. Reset empties the output
// register and returns the block to idle; no other state is kept.
module integer_to_ascii_formatter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_ready,
    input  i2af_pkg::in_item_t  num_item,
    output logic                chr_valid,
    input  logic                chr_ready,
    output i2af_pkg::out_item_t chr_item
);
    import i2af_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int TOP_LSB = VALUE_W - NIB_W;

    logic [2:0]         state_reg,     state_next;
    logic [VALUE_W-1:0] digits_reg,    digits_next;
    logic [COUNT_W-1:0] left_reg,      left_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic               neg_reg,       neg_next;
    logic               upper_reg,     upper_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg,  out_item_next;

    logic [WORD_W-1:0]  low_word;
    logic               is_neg;
    logic [WORD_W-1:0]  mag;
    logic               conv_start;
    logic               conv_done;
    logic [BCD_W-1:0]   conv_bcd;
    logic               slot_free;
    logic [NIB_W-1:0]   top_nib;

    assign low_word  = num_item.value[WORD_W-1:0];
    assign is_neg    = (num_item.cmd == CMD_SDEC) && low_word[WORD_W-1];
    // two's complement magnitude; the most negative word maps onto itself
    assign mag       = is_neg ? (~low_word + 1'b1) : low_word;
    assign slot_free = !out_valid_reg || chr_ready;
    assign top_nib   = digits_reg[VALUE_W-1:TOP_LSB];

    i2af_bcd_conv u_bcd_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .bin   (mag),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    always_comb
    begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        left_next      = left_reg;
        count_next     = count_reg;
        neg_next       = neg_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        conv_start     = 1'b0;

        // drop the shown item once the receiver takes it
        if (out_valid_reg && chr_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (num_valid)
                begin
                    upper_next = num_item.upper_case;
                    neg_next   = is_neg;
                    count_next = '0;
                    unique case (num_item.cmd)
                        CMD_SDEC, CMD_UDEC:
                        begin
                            conv_start = 1'b1;
                            state_next = ST_CONV;
                        end
                        CMD_HEX32:
                        begin
                            digits_next = {low_word, {(VALUE_W-WORD_W){1'b0}}};
                            left_next   = COUNT_W'(WORD_W / NIB_W);
                            state_next  = ST_SKIP;
                        end
                        CMD_HEX64:
                        begin
                            digits_next = num_item.value;
                            left_next   = COUNT_W'(VALUE_W / NIB_W);
                            state_next  = ST_SKIP;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                // align the BCD digits to the top of the digit register
                if (conv_done)
                begin
                    digits_next = {conv_bcd, {(VALUE_W-BCD_W){1'b0}}};
                    left_next   = COUNT_W'(BCD_DIGITS);
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keeping the final digit
                if (top_nib == '0 && left_reg > COUNT_W'(1))
                begin
                    digits_next = {digits_reg[TOP_LSB-1:0], {NIB_W{1'b0}}};
                    left_next   = left_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.char_out   = CHAR_MINUS;
                    out_item_next.last       = 1'b0;
                    out_item_next.char_count = count_reg + 1'b1;
                    count_next               = count_reg + 1'b1;
                    state_next               = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // advance one digit per free output slot
                if (slot_free)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.char_out   = digit_char(top_nib, upper_reg);
                    out_item_next.last       = (left_reg == COUNT_W'(1));
                    out_item_next.char_count = count_reg + 1'b1;
                    count_next               = count_reg + 1'b1;
                    digits_next = {digits_reg[TOP_LSB-1:0], {NIB_W{1'b0}}};
                    left_next   = left_reg - 1'b1;
                    if (left_reg == COUNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg   <= digits_next;
        left_reg     <= left_next;
        count_reg    <= count_next;
        neg_reg      <= neg_next;
        upper_reg    <= upper_next;
        out_item_reg <= out_item_next;
    end

    assign num_ready = (state_reg == ST_IDLE);
    assign chr_valid = out_valid_reg;
    assign chr_item  = out_item_reg;

endmodule

@@ sv/i2af_bcd_conv.sv @@
module i2af_bcd_conv (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [i2af_pkg::WORD_W-1:0] bin,
    output logic                     done,
    output logic [i2af_pkg::BCD_W-1:0]  bcd
);
    import i2af_pkg::*;

    logic [WORD_W-1:0]    bin_reg;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     adj;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // shift-add-3: correct every digit, then take in one binary bit
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            adj[i*NIB_W +: NIB_W] = bcd_adjust(bcd_reg[i*NIB_W +: NIB_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= bin;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[WORD_W-2:0], 1'b0};
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[WORD_W-1]};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

@@ sv/i2af_checker.sv @@
`include "integer_to_ascii_formatter_unit_assert.svh"

module i2af_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                num_valid,
    input logic                num_ready,
    input logic                chr_valid,
    input logic                chr_ready,
    input i2af_pkg::out_item_t chr_item
);
    import i2af_pkg::*;

    `I2AF_ASSERT_NXT(a_chr_hold, chr_valid && !chr_ready,
        chr_valid && $stable(chr_item), "character changed while stalled")
    `I2AF_ASSERT_IMP(a_count_range, chr_valid,
        chr_item.char_count != 5'd0 && chr_item.char_count <= 5'd16,
        "character count out of range")
    `I2AF_ASSERT_IMP(a_minus_first, chr_valid && chr_item.char_out == CHAR_MINUS,
        !chr_item.last && chr_item.char_count == 5'd1, "minus sign not leading")
    `I2AF_ASSERT_NXT(a_busy_after_num, num_valid && num_ready, !num_ready,
        "second number taken straight after the first")
    `I2AF_ASSERT_IMP(a_busy_mid_text, chr_valid && !chr_item.last, !num_ready,
        "ready for a number before the last character")

endmodule

bind integer_to_ascii_formatter_unit i2af_checker u_i2af_checker (.*);
